[hdl/pidc_pkg.sv]
// Shared constants, register map and types for the PID step block.
package pidc_pkg;

    // Default widths of the error sample and of the fixed-point fraction.
    localparam int ERROR_WIDTH = 13;
    localparam int FRAC_BITS   = 16;

    // Fixed field widths.
    localparam int GAIN_WIDTH  = 32;
    localparam int STEP_WIDTH  = 16;
    localparam int LIMIT_WIDTH = 15;
    localparam int OUT_WIDTH   = 48;

    // Digit size of the serial multiplier.
    localparam int DIGIT_BITS = 8;

    // Digits in the longest multiplier operand, which is either the integral
    // or the scaled error difference.
    localparam int MUL_OPERAND_MAX = (FRAC_BITS + LIMIT_WIDTH + 1 > ERROR_WIDTH + STEP_WIDTH + 1)
                                   ? FRAC_BITS + LIMIT_WIDTH + 1
                                   : ERROR_WIDTH + STEP_WIDTH + 1;
    localparam int MUL_DIGITS = (MUL_OPERAND_MAX + DIGIT_BITS - 1) / DIGIT_BITS;

    // Digit counter width; covers up to seven digits per operand.
    localparam int DIGIT_CNT_W = 3;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KP             = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KI             = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KD             = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_RATE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;

    // Register reset values.
    localparam logic [STEP_WIDTH-1:0]  STEP_TIME_RESET      = 16'd66;
    localparam logic [STEP_WIDTH-1:0]  STEP_RATE_RESET      = 16'd1000;
    localparam logic [LIMIT_WIDTH-1:0] INTEGRAL_LIMIT_RESET = 15'd1000;

    // Current register contents.
    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0] kp;
        logic signed [GAIN_WIDTH-1:0] ki;
        logic signed [GAIN_WIDTH-1:0] kd;
        logic [STEP_WIDTH-1:0]        step_time;
        logic [STEP_WIDTH-1:0]        step_rate;
        logic [LIMIT_WIDTH-1:0]       integral_limit;
    } cfg_t;

    // Command to the serial multiplier.
    typedef struct packed {
        logic                   start;
        logic [DIGIT_CNT_W-1:0] digits;
    } mul_ctrl_t;

endpackage

[hdl/pidc_if.sv]
// Input sample channel.
interface pidc_in_if #(
    parameter int ERROR_WIDTH = pidc_pkg::ERROR_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [ERROR_WIDTH-1:0] error;
    logic                          restart;

    modport source (output valid, output error, output restart, input ready);
    modport sink   (input valid, input error, input restart, output ready);
endinterface

// Result channel.
interface pidc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pidc_pkg::OUT_WIDTH-1:0] control;
    logic                                  integral_clamped;

    modport source (output valid, output control, output integral_clamped, input ready);
    modport sink   (input valid, input control, input integral_clamped, output ready);
endinterface

// Configuration write channel.
interface pidc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pidc_pkg::CFG_INDEX_W-1:0] index;
    logic [pidc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/pidc_cfg_regs.sv]
// Configuration register file. Writes to indexes beyond the map are dropped.
module pidc_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    pidc_cfg_if.sink          cfg,
    output pidc_pkg::cfg_t    regs
);

    localparam int GW = pidc_pkg::GAIN_WIDTH;
    localparam int SW = pidc_pkg::STEP_WIDTH;
    localparam int LW = pidc_pkg::LIMIT_WIDTH;

    pidc_pkg::cfg_t regs_reg;

    // The register file never stalls a transaction.
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.kp             <= '0;
            regs_reg.ki             <= '0;
            regs_reg.kd             <= '0;
            regs_reg.step_time      <= pidc_pkg::STEP_TIME_RESET;
            regs_reg.step_rate      <= pidc_pkg::STEP_RATE_RESET;
            regs_reg.integral_limit <= pidc_pkg::INTEGRAL_LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                pidc_pkg::REG_KP:             regs_reg.kp <= cfg.data[GW-1:0];
                pidc_pkg::REG_KI:             regs_reg.ki <= cfg.data[GW-1:0];
                pidc_pkg::REG_KD:             regs_reg.kd <= cfg.data[GW-1:0];
                pidc_pkg::REG_STEP_TIME:      regs_reg.step_time <= cfg.data[SW-1:0];
                pidc_pkg::REG_STEP_RATE:      regs_reg.step_rate <= cfg.data[SW-1:0];
                pidc_pkg::REG_INTEGRAL_LIMIT: regs_reg.integral_limit <= cfg.data[LW-1:0];
                default:                      ;
            endcase
        end
    end

endmodule

[hdl/pidc_mul_serial.sv]
// Digit-serial signed multiplier. The multiplicand is held in parallel, the
// multiplier is shifted in one digit per cycle, least significant first, and
// the product leaves the low end of the accumulator one digit per cycle into
// a shift register. The last digit is taken as signed.
module pidc_mul_serial #(
    parameter int NUM_DIGITS = pidc_pkg::MUL_DIGITS
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  pidc_pkg::mul_ctrl_t                                      ctrl,
    input  logic signed [pidc_pkg::GAIN_WIDTH-1:0]                   multiplicand,
    input  logic signed [NUM_DIGITS*pidc_pkg::DIGIT_BITS-1:0]        multiplier,
    output logic                                                     done,
    output logic signed [pidc_pkg::GAIN_WIDTH+NUM_DIGITS*pidc_pkg::DIGIT_BITS:0] product
);

    localparam int D     = pidc_pkg::DIGIT_BITS;
    localparam int AW    = pidc_pkg::GAIN_WIDTH;
    localparam int BW    = NUM_DIGITS * D;
    localparam int CNT_W = pidc_pkg::DIGIT_CNT_W;

    logic signed [AW-1:0]    mcand_reg;
    logic [BW-1:0]           mplier_reg;
    logic signed [AW:0]      hi_reg;
    logic [BW-1:0]           lo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;

    logic                    last_digit;
    logic signed [D:0]       digit;
    logic signed [AW+D:0]    partial;
    logic [AW+D+1:0]         acc_sum;

    // Current digit; the top digit of the operand carries its sign.
    assign last_digit = (cnt_reg == CNT_W'(1));
    assign digit = last_digit ? {mplier_reg[D-1], mplier_reg[D-1:0]}
                              : {1'b0, mplier_reg[D-1:0]};

    // One digit product and accumulate.
    assign partial = mcand_reg * digit;
    assign acc_sum = {{(D+1){hi_reg[AW]}}, hi_reg} + {partial[AW+D], partial};

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

    // Sequencing of the digit count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            cnt_reg  <= ctrl.digits;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last_digit;
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Operand and product shift registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mcand_reg  <= multiplicand;
            mplier_reg <= multiplier;
            hi_reg     <= '0;
            lo_reg     <= '0;
        end
        else if (cnt_reg != '0)
        begin
            mplier_reg <= {{D{1'b0}}, mplier_reg[BW-1:D]};
            hi_reg     <= acc_sum[AW+D:D];
            lo_reg     <= {acc_sum[D-1:0], lo_reg[BW-1:D]};
        end
    end

endmodule

[hdl/pid_controller_step.sv]
// Channel   Direction  Payload
// -------   ---------  -------------------------------------------------
// sample    in         error (signed), restart
// result    out        control (signed Q.FRAC_BITS, 48 bits), integral_clamped
// cfg       in         index, data (register write, always ready)
//
// One item runs five products on one digit-serial multiplier, 8 bits per
// cycle, of 2, 2, 2, 4 and 4 digits in turn, then loads the result and
// returns to idle, where it accepts again; no new sample is taken while an
// item is in progress. Reset clears the integral, the previous error and
// both handshakes. A waiting result blocks the next sample only when a
// second result is ready before the first is taken.
module pid_controller_step #(
    parameter int ERROR_WIDTH = pidc_pkg::ERROR_WIDTH,
    parameter int FRAC_BITS   = pidc_pkg::FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    pidc_in_if.sink      sample,
    pidc_out_if.source   result,
    pidc_cfg_if.sink     cfg
);

    localparam int D     = pidc_pkg::DIGIT_BITS;
    localparam int AW    = pidc_pkg::GAIN_WIDTH;
    localparam int STW   = pidc_pkg::STEP_WIDTH;
    localparam int LW    = pidc_pkg::LIMIT_WIDTH;
    localparam int OW    = pidc_pkg::OUT_WIDTH;
    localparam int CNT_W = pidc_pkg::DIGIT_CNT_W;

    // Operand widths.
    localparam int EW      = ERROR_WIDTH;
    localparam int DF_W    = EW + 1;
    localparam int IW      = FRAC_BITS + LW + 1;
    localparam int DR_W    = EW + STW + 1;
    localparam int INC16_W = EW + STW + 1;
    localparam int INC_UP  = (FRAC_BITS >= STW) ? FRAC_BITS - STW : 0;
    localparam int INC_DN  = (FRAC_BITS < STW) ? STW - FRAC_BITS : 0;
    localparam int INC_W   = INC16_W + INC_UP;
    localparam int SUM_W   = ((IW > INC_W) ? IW : INC_W) + 1;
    localparam int P_W     = AW + EW;
    localparam int IP_W    = AW + IW;
    localparam int D_W     = AW + DR_W;
    localparam int TOT_W   = D_W + 2;

    // Multiplier geometry.
    localparam int MUL_MAX    = (IW > DR_W) ? IW : DR_W;
    localparam int MUL_DIGITS = (MUL_MAX + D - 1) / D;
    localparam int BW         = MUL_DIGITS * D;
    localparam int PW         = AW + 1 + BW;

    // Digits per operand and product alignment.
    localparam int NE_I  = (EW + D - 1) / D;
    localparam int NDF_I = (DF_W + D - 1) / D;
    localparam int NI_I  = (IW + D - 1) / D;
    localparam int NDR_I = (DR_W + D - 1) / D;
    localparam logic [CNT_W-1:0] N_E  = CNT_W'(NE_I);
    localparam logic [CNT_W-1:0] N_DF = CNT_W'(NDF_I);
    localparam logic [CNT_W-1:0] N_I  = CNT_W'(NI_I);
    localparam logic [CNT_W-1:0] N_DR = CNT_W'(NDR_I);
    localparam int SH_E  = (MUL_DIGITS - NE_I) * D;
    localparam int SH_DF = (MUL_DIGITS - NDF_I) * D;
    localparam int SH_I  = (MUL_DIGITS - NI_I) * D;
    localparam int SH_DR = (MUL_DIGITS - NDR_I) * D;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INC  = 3'd1;
    localparam logic [2:0] ST_DR   = 3'd2;
    localparam logic [2:0] ST_P    = 3'd3;
    localparam logic [2:0] ST_I    = 3'd4;
    localparam logic [2:0] ST_D    = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    pidc_pkg::cfg_t      regs;
    pidc_pkg::mul_ctrl_t mul_ctrl;
    logic signed [AW-1:0] mcand;
    logic signed [BW-1:0] mplier;
    logic                 mul_done;
    logic signed [PW-1:0] mul_prod;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic signed [EW-1:0]    err_reg;
    logic signed [EW-1:0]    last_err_reg;
    logic signed [IW-1:0]    integral_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    clamp_pend_reg;
    logic                    clamped_reg;
    logic signed [DR_W-1:0]  dr_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic                    out_valid_reg;
    logic signed [OW-1:0]    control_reg;
    logic                    clamp_out_reg;

    logic                     accept;
    logic                     out_free;
    logic signed [EW-1:0]     err_in;
    logic signed [DF_W-1:0]   diff;
    logic signed [PW-1:0]     prod_e;
    logic signed [PW-1:0]     prod_df;
    logic signed [PW-1:0]     prod_i;
    logic signed [PW-1:0]     prod_dr;
    logic signed [INC16_W-1:0] inc16;
    logic signed [INC_W-1:0]  inc_al;
    logic signed [SUM_W-1:0]  sum_w;
    logic signed [SUM_W-1:0]  lim_pos;
    logic signed [SUM_W-1:0]  lim_neg;
    logic signed [P_W-1:0]    p_term;
    logic signed [IP_W-FRAC_BITS-1:0] i_term;
    logic signed [D_W-1:0]    d_term;
    logic                     pos_over;
    logic                     neg_over;
    logic signed [OW-1:0]     sat_value;

    pidc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pidc_mul_serial #(
        .NUM_DIGITS (MUL_DIGITS)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (mul_ctrl),
        .multiplicand (mcand),
        .multiplier   (mplier),
        .done         (mul_done),
        .product      (mul_prod)
    );

    // Handshakes.
    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == ST_IDLE);
    assign out_free     = !out_valid_reg || result.ready;
    assign err_in       = sample.error;

    assign result.valid            = out_valid_reg;
    assign result.control          = control_reg;
    assign result.integral_clamped = clamp_out_reg;

    // Product alignment for each operand length.
    assign prod_e  = mul_prod >>> SH_E;
    assign prod_df = mul_prod >>> SH_DF;
    assign prod_i  = mul_prod >>> SH_I;
    assign prod_dr = mul_prod >>> SH_DR;

    assign inc16  = prod_e[INC16_W-1:0];
    assign p_term = prod_e[P_W-1:0];
    assign i_term = prod_i[IP_W-1:FRAC_BITS];
    assign d_term = prod_dr[D_W-1:0];

    // Integral increment aligned to the output fraction, floor when narrowing.
    assign inc_al = (INC_W'(inc16) <<< INC_UP) >>> INC_DN;
    assign sum_w  = SUM_W'(integral_reg) + SUM_W'(inc_al);

    // Clamp bounds in the integral format.
    assign lim_pos = SUM_W'({regs.integral_limit, {FRAC_BITS{1'b0}}});
    assign lim_neg = -lim_pos;

    assign diff = DF_W'(err_reg) - DF_W'(last_err_reg);

    // Output saturation to the 48-bit range.
    assign pos_over  = !total_reg[TOT_W-1] && (|total_reg[TOT_W-2:OW-1]);
    assign neg_over  = total_reg[TOT_W-1] && !(&total_reg[TOT_W-2:OW-1]);
    assign sat_value = pos_over ? {1'b0, {(OW-1){1'b1}}}
                     : neg_over ? {1'b1, {(OW-1){1'b0}}}
                     : total_reg[OW-1:0];

    // Multiplier command: each product starts in the cycle the previous one
    // is finished.
    always_comb
    begin
        mul_ctrl.start  = 1'b0;
        mul_ctrl.digits = N_E;
        mcand           = AW'(regs.step_time);
        mplier          = BW'(err_in);
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_ctrl.start = accept;
            end
            ST_INC:
            begin
                mul_ctrl.start  = mul_done;
                mul_ctrl.digits = N_DF;
                mcand           = AW'(regs.step_rate);
                mplier          = BW'(diff);
            end
            ST_DR:
            begin
                mul_ctrl.start = mul_done;
                mcand          = regs.kp;
                mplier         = BW'(err_reg);
            end
            ST_P:
            begin
                mul_ctrl.start  = mul_done;
                mul_ctrl.digits = N_I;
                mcand           = regs.ki;
                mplier          = BW'(integral_reg);
            end
            ST_I:
            begin
                mul_ctrl.start  = mul_done;
                mul_ctrl.digits = N_DR;
                mcand           = regs.kd;
                mplier          = BW'(dr_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept)   state_next = ST_INC;
            ST_INC:  if (mul_done) state_next = ST_DR;
            ST_DR:   if (mul_done) state_next = ST_P;
            ST_P:    if (mul_done) state_next = ST_I;
            ST_I:    if (mul_done) state_next = ST_D;
            ST_D:    if (mul_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, controller history and the result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            integral_reg   <= '0;
            last_err_reg   <= '0;
            clamp_pend_reg <= 1'b0;
            clamped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clamp_pend_reg <= (state_reg == ST_INC) && mul_done;

            // Restart clears the history before this step runs.
            if (accept)
            begin
                clamped_reg <= 1'b0;
                if (sample.restart)
                begin
                    integral_reg <= '0;
                    last_err_reg <= '0;
                end
            end

            // Clamp the updated integral in the cycle after the add is registered.
            if (clamp_pend_reg)
            begin
                if (sum_reg > lim_pos)
                begin
                    integral_reg <= lim_pos[IW-1:0];
                    clamped_reg  <= 1'b1;
                end
                else if (sum_reg < lim_neg)
                begin
                    integral_reg <= lim_neg[IW-1:0];
                    clamped_reg  <= 1'b1;
                end
                else
                begin
                    integral_reg <= sum_reg[IW-1:0];
                end
            end

            if ((state_reg == ST_DR) && mul_done)
            begin
                last_err_reg <= err_reg;
            end

            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers: sample, intermediate products and the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg <= err_in;
        end
        if ((state_reg == ST_INC) && mul_done)
        begin
            sum_reg <= sum_w;
        end
        if ((state_reg == ST_DR) && mul_done)
        begin
            dr_reg <= prod_df[DR_W-1:0];
        end
        if ((state_reg == ST_P) && mul_done)
        begin
            total_reg <= TOT_W'(p_term);
        end
        if ((state_reg == ST_I) && mul_done)
        begin
            total_reg <= total_reg + TOT_W'(i_term);
        end
        if ((state_reg == ST_D) && mul_done)
        begin
            total_reg <= total_reg + TOT_W'(d_term);
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            control_reg   <= sat_value;
            clamp_out_reg <= clamped_reg;
        end
    end

endmodule
